// File: hw/rtl/pjt_pkg.sv
package pjt_pkg;

  localparam int TICK_BITS       = 16;
  localparam int ANGLE_FRAC_BITS = 16;

  localparam int ANGLE_W = 26;
  localparam int WIDE_W  = 48;
  localparam int Q_BITS  = 30;             // fraction bits of s and its powers
  localparam int S_W     = Q_BITS + 1;     // s <= 1.0
  localparam int POLY_W  = 40;             // signed polynomial terms, |p''| < 2^38
  localparam int DIFF_W  = ANGLE_W + 1;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DIV_W   = 50;
  localparam int DSR_W   = 2 * TICK_BITS;
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam int RATE_SHIFT = ANGLE_FRAC_BITS - 2;

  localparam logic signed [ANGLE_W-1:0] START_RESET = 26'sd0;
  localparam logic signed [ANGLE_W-1:0] END_RESET   = 26'sd5898240;
  localparam logic [TICK_BITS-1:0]      DUR_RESET   = 16'd200;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_DUR   = 2'd2,
    REG_MODE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_S     = 2'd0,
    DIV_RATE  = 2'd1,
    DIV_ACCEL = 2'd2
  } div_sel_t;

  typedef enum logic [1:0] {
    TERM_ANGLE = 2'd0,
    TERM_RATE  = 2'd1,
    TERM_ACCEL = 2'd2
  } term_sel_t;

  typedef struct packed {
    logic      setup;
    logic      div_start;
    div_sel_t  div_sel;
    logic      cap_s;
    logic      pow_step;
    logic      poly;
    logic      mul_lo;
    logic      mul_hi;
    term_sel_t term;
    logic      take_angle;
    logic      cap_rate;
    logic      cap_accel;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

endpackage

// File: hw/rtl/pjt_div.sv
module pjt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pjt_pkg::DIV_W-1:0] dividend,
  input  logic [pjt_pkg::DSR_W-1:0] divisor,
  output logic                      busy,
  output logic [pjt_pkg::DIV_W-1:0] quotient
);
  import pjt_pkg::*;

  // restoring divide, one quotient bit per cycle
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DSR_W:0]   partial;
  logic             fits;

  assign partial = {rem, quotient[DIV_W-1]};
  assign fits    = partial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DSR_W'(partial - {1'b0, dsr}) : partial[DSR_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

// File: hw/rtl/pjt_datapath.sv
module pjt_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [pjt_pkg::ANGLE_W-1:0] start_angle,
  input  logic signed [pjt_pkg::ANGLE_W-1:0] end_angle,
  input  logic [pjt_pkg::TICK_BITS-1:0]      duration_ticks,
  input  logic                               profile_mode,
  input  logic                               restart,
  input  pjt_pkg::cmd_t                      cmd,
  output pjt_pkg::status_t                   status,
  output logic [pjt_pkg::TICK_BITS-1:0]      tick_index,
  output logic signed [pjt_pkg::ANGLE_W-1:0] angle,
  output logic signed [pjt_pkg::WIDE_W-1:0]  angular_rate,
  output logic signed [pjt_pkg::WIDE_W-1:0]  angular_accel,
  output logic                               last_sample
);
  import pjt_pkg::*;

  // move state
  logic [TICK_BITS-1:0] tick_counter;
  logic                 move_done;

  // per-sample registers
  logic [TICK_BITS-1:0] k_r, n_r;
  logic [DSR_W-1:0]     nn_r;
  logic                 last_r;
  logic [S_W-1:0]       s_r, s2, s3, s4, s5;
  logic signed [POLY_W-1:0] p_r, p1_r, p2_r;
  logic [PROD_W-1:0]    acc;
  logic                 neg_r;
  logic signed [ANGLE_W-1:0] angle_r;
  logic signed [WIDE_W-1:0]  rate_r, accel_r;

  // tick selection
  logic [TICK_BITS-1:0] n_eff, k_cur, k_sel;
  logic                 done_cur, last_sel;

  always_comb begin
    n_eff    = (duration_ticks == '0) ? TICK_BITS'(1) : duration_ticks;
    k_cur    = restart ? '0 : tick_counter;
    done_cur = restart ? 1'b0 : move_done;
    k_sel    = (done_cur || k_cur >= n_eff) ? n_eff : k_cur;
    last_sel = (k_sel == n_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      move_done    <= 1'b0;
    end else if (cmd.setup) begin
      tick_counter <= last_sel ? k_sel : k_sel + 1'b1;
      move_done    <= last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      k_r    <= k_sel;
      n_r    <= n_eff;
      nn_r   <= DSR_W'(n_eff) * DSR_W'(n_eff);
      last_r <= last_sel;
    end
  end

  // divider
  logic [DIV_W-1:0]  div_dividend, div_q;
  logic [DSR_W-1:0]  div_divisor;
  logic              div_busy;
  logic [PROD_W-1:0] acc_rate_rnd, acc_accel_rnd;

  assign acc_rate_rnd  = acc + (PROD_W'(n_r) << (ANGLE_FRAC_BITS - 3));
  assign acc_accel_rnd = acc + (PROD_W'(nn_r) << (ANGLE_FRAC_BITS - 3));

  always_comb begin
    case (cmd.div_sel)
      DIV_S: begin
        div_dividend = DIV_W'({k_sel, Q_BITS'(0)}) + DIV_W'(n_eff >> 1);
        div_divisor  = DSR_W'(n_eff);
      end
      DIV_RATE: begin
        div_dividend = acc_rate_rnd[RATE_SHIFT +: DIV_W];
        div_divisor  = DSR_W'(n_r);
      end
      DIV_ACCEL: begin
        div_dividend = acc_accel_rnd[RATE_SHIFT +: DIV_W];
        div_divisor  = nn_r;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DSR_W'(1);
      end
    endcase
  end

  pjt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign status.div_busy = div_busy;

  // powers of s: shift chain, newest power enters at s5
  logic [2*S_W-1:0] pow_prod;
  assign pow_prod = (2*S_W)'(s5) * (2*S_W)'(s_r) + (2*S_W)'(1 << (Q_BITS - 1));

  always_ff @(posedge clk) begin
    if (cmd.cap_s) begin
      s_r <= div_q[S_W-1:0];
      s5  <= div_q[S_W-1:0];
    end else if (cmd.pow_step) begin
      s2 <= s3;
      s3 <= s4;
      s4 <= s5;
      s5 <= pow_prod[Q_BITS +: S_W];
    end
  end

  // polynomial terms
  logic signed [POLY_W-1:0] e1, e2, e3, e4, e5;
  assign e1 = $signed({{(POLY_W-S_W){1'b0}}, s_r});
  assign e2 = $signed({{(POLY_W-S_W){1'b0}}, s2});
  assign e3 = $signed({{(POLY_W-S_W){1'b0}}, s3});
  assign e4 = $signed({{(POLY_W-S_W){1'b0}}, s4});
  assign e5 = $signed({{(POLY_W-S_W){1'b0}}, s5});

  always_ff @(posedge clk) begin
    if (cmd.poly) begin
      if (profile_mode) begin
        p_r  <= 40'sd10 * e3 - 40'sd15 * e4 + 40'sd6 * e5;
        p1_r <= 40'sd30 * e2 - 40'sd60 * e3 + 40'sd30 * e4;
        p2_r <= 40'sd60 * e1 - 40'sd180 * e2 + 40'sd120 * e3;
      end else begin
        p_r  <= 40'sd3 * e2 - 40'sd2 * e3;
        p1_r <= 40'sd6 * e1 - 40'sd6 * e2;
        p2_r <= (40'sd6 <<< Q_BITS) - 40'sd12 * e1;
      end
    end
  end

  // distance times term, as magnitudes over two multiplier passes
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_mag;
  logic signed [POLY_W-1:0] term;
  logic [POLY_W-1:0]        term_mag;
  logic [MUL_W-1:0]         mul_b;
  logic [PROD_W-1:0]        prod;

  assign diff     = DIFF_W'(end_angle) - DIFF_W'(start_angle);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  always_comb begin
    case (cmd.term)
      TERM_ANGLE: term = p_r;
      TERM_RATE:  term = p1_r;
      TERM_ACCEL: term = p2_r;
      default:    term = p_r;
    endcase
  end

  assign term_mag = term[POLY_W-1] ? POLY_W'(-term) : POLY_W'(term);
  assign mul_b    = cmd.mul_hi ? MUL_W'(term_mag[POLY_W-1:MUL_W]) : term_mag[MUL_W-1:0];
  assign prod     = PROD_W'(MUL_W'(diff_mag)) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      acc   <= prod;
      neg_r <= diff[DIFF_W-1] ^ term[POLY_W-1];
    end else if (cmd.mul_hi) begin
      acc <= acc + (prod << MUL_W);
    end
  end

  // angle: start + round(d*p / 2^30), saturated
  localparam int AR_W = PROD_W - Q_BITS;
  localparam int AS_W = AR_W + 2;
  logic [PROD_W-1:0]      acc_ang_rnd;
  logic signed [AS_W-1:0] ang_off, ang_sum;
  localparam logic signed [AS_W-1:0] ANG_MAX = AS_W'((1 << (ANGLE_W - 1)) - 1);
  localparam logic signed [AS_W-1:0] ANG_MIN = -AS_W'(1 << (ANGLE_W - 1));

  assign acc_ang_rnd = acc + PROD_W'(1 << (Q_BITS - 1));
  assign ang_off = neg_r ? -$signed({2'b00, acc_ang_rnd[PROD_W-1:Q_BITS]})
                         :  $signed({2'b00, acc_ang_rnd[PROD_W-1:Q_BITS]});
  assign ang_sum = ang_off + AS_W'(start_angle);

  always_ff @(posedge clk) begin
    if (cmd.take_angle) begin
      if (ang_sum > ANG_MAX) begin
        angle_r <= ANGLE_W'(ANG_MAX);
      end else if (ang_sum < ANG_MIN) begin
        angle_r <= ANGLE_W'(ANG_MIN);
      end else begin
        angle_r <= ANGLE_W'(ang_sum);
      end
    end
  end

  // signed, saturated quotient
  localparam logic [DIV_W-1:0] WIDE_LIM = DIV_W'(1) << (WIDE_W - 1);
  logic signed [WIDE_W-1:0] wide_res;

  always_comb begin
    if (neg_r) begin
      wide_res = (div_q > WIDE_LIM) ? $signed(WIDE_W'(WIDE_LIM))
                                    : $signed(WIDE_W'(-div_q));
    end else begin
      wide_res = (div_q >= WIDE_LIM) ? $signed(WIDE_W'(WIDE_LIM - 1'b1))
                                     : $signed(WIDE_W'(div_q));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_rate) begin
      rate_r <= wide_res;
    end
    if (cmd.cap_accel) begin
      accel_r <= wide_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tick_index    <= k_r;
      angle         <= angle_r;
      angular_rate  <= rate_r;
      angular_accel <= accel_r;
      last_sample   <= last_r;
    end
  end

endmodule

// File: hw/rtl/pjt_ctrl.sv
module pjt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  pjt_pkg::status_t status,
  output pjt_pkg::cmd_t    cmd
);
  import pjt_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_SDIV   = 12'b000000000010,
    ST_POW    = 12'b000000000100,
    ST_POLY   = 12'b000000001000,
    ST_MLO    = 12'b000000010000,
    ST_MHI    = 12'b000000100000,
    ST_ANG    = 12'b000001000000,
    ST_RSTART = 12'b000010000000,
    ST_RDIV   = 12'b000100000000,
    ST_ASTART = 12'b001000000000,
    ST_ADIV   = 12'b010000000000,
    ST_FINISH = 12'b100000000000
  } state_t;

  state_t    state, state_next;
  term_sel_t term, term_next;
  logic [1:0] pow_cnt, pow_cnt_next;
  logic      out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    term_next    = term;
    pow_cnt_next = pow_cnt;
    cmd          = '0;
    cmd.term     = term;
    cmd.div_sel  = DIV_S;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.setup     = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = ST_SDIV;
        end
      end
      ST_SDIV: begin
        if (!status.div_busy) begin
          cmd.cap_s    = 1'b1;
          pow_cnt_next = '0;
          state_next   = ST_POW;
        end
      end
      ST_POW: begin
        cmd.pow_step = 1'b1;
        pow_cnt_next = pow_cnt + 1'b1;
        if (pow_cnt == 2'd3) begin
          state_next = ST_POLY;
        end
      end
      ST_POLY: begin
        cmd.poly   = 1'b1;
        term_next  = TERM_ANGLE;
        state_next = ST_MLO;
      end
      ST_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MHI;
      end
      ST_MHI: begin
        cmd.mul_hi = 1'b1;
        case (term)
          TERM_ANGLE: state_next = ST_ANG;
          TERM_RATE:  state_next = ST_RSTART;
          TERM_ACCEL: state_next = ST_ASTART;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_ANG: begin
        cmd.take_angle = 1'b1;
        term_next      = TERM_RATE;
        state_next     = ST_MLO;
      end
      ST_RSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATE;
        state_next    = ST_RDIV;
      end
      ST_RDIV: begin
        if (!status.div_busy) begin
          cmd.cap_rate = 1'b1;
          term_next    = TERM_ACCEL;
          state_next   = ST_MLO;
        end
      end
      ST_ASTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ACCEL;
        state_next    = ST_ADIV;
      end
      ST_ADIV: begin
        if (!status.div_busy) begin
          cmd.cap_accel = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      term      <= TERM_ANGLE;
      pow_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      term    <= term_next;
      pow_cnt <= pow_cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/polynomial_joint_trajectory.sv
// Rest-to-rest joint trajectory generator, cubic or quintic profile.
// Input channel (in_valid / in_stall / restart): one request per servo tick.
// restart = 1 clears the tick counter before that sample is formed.
// Output channel (out_valid / out_stall / payload): one result per request
// with tick_index k, angle (Q.16 deg), angular_rate and angular_accel
// (Q.32 deg per tick, per tick squared, saturated) and last_sample at k = N.
// After the last sample every request repeats k = N until a restart.
// Configuration (cfg_write / cfg_index / cfg_data): 0 start angle,
// 1 end angle, 2 duration in ticks, 3 profile mode; write only while idle.
// From the accepting edge to out_valid the block runs three passes of the
// shared one-bit-per-cycle divider (for s = k/N, the rate and the
// acceleration), four power steps, a polynomial step, six multiplier passes
// with three captures, and one output load.
// One request is in work at a time; in_stall is high while it runs.
// The result sits in an output register, so a stalled receiver only holds
// up the following request once its result is ready to be written.
// Reset (rst, synchronous) clears the tick counter, the done flag, the
// output valid and loads the register defaults.
module polynomial_joint_trajectory (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [1:0]                         cfg_index,
  input  logic [pjt_pkg::ANGLE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pjt_pkg::TICK_BITS-1:0]      tick_index,
  output logic signed [pjt_pkg::ANGLE_W-1:0] angle,
  output logic signed [pjt_pkg::WIDE_W-1:0]  angular_rate,
  output logic signed [pjt_pkg::WIDE_W-1:0]  angular_accel,
  output logic                               last_sample
);
  import pjt_pkg::*;

  logic signed [ANGLE_W-1:0] start_angle, end_angle;
  logic [TICK_BITS-1:0]      duration_ticks;
  logic                      profile_mode;
  cmd_t                      cmd;
  status_t                   status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle    <= START_RESET;
      end_angle      <= END_RESET;
      duration_ticks <= DUR_RESET;
      profile_mode   <= 1'b1;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_START: start_angle    <= $signed(cfg_data);
        REG_END:   end_angle      <= $signed(cfg_data);
        REG_DUR:   duration_ticks <= cfg_data[TICK_BITS-1:0];
        REG_MODE:  profile_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pjt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pjt_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .start_angle    (start_angle),
    .end_angle      (end_angle),
    .duration_ticks (duration_ticks),
    .profile_mode   (profile_mode),
    .restart        (restart),
    .cmd            (cmd),
    .status         (status),
    .tick_index     (tick_index),
    .angle          (angle),
    .angular_rate   (angular_rate),
    .angular_accel  (angular_accel),
    .last_sample    (last_sample)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pjt_pkg::*;

  localparam logic MODE_CUBIC   = 1'b0;
  localparam logic MODE_QUINTIC = 1'b1;
  localparam int   ANGLE_LIM    = 23592960;  // +/-360 deg in Q.16
  localparam int   TARGET_ITEMS = 1200;
  localparam int   PEND_DEPTH   = 16;

  // one expected trajectory sample
  typedef struct {
    logic [TICK_BITS-1:0]      tick;
    logic signed [ANGLE_W-1:0] ang;
    logic signed [WIDE_W-1:0]  rate;
    logic signed [WIDE_W-1:0]  accel;
    logic                      last;
  } sample_t;

  // Trajectory scoreboard: keeps its own copy of the registers and the tick
  // state, turns every accepted tick request into the expected sample.
  class traj_board;
    longint          q_start, q_end;
    longint unsigned dur;
    bit              mode;
    longint unsigned ticks;
    bit              done;
    sample_t         pend[PEND_DEPTH];
    int unsigned     wr_cnt, rd_cnt;
    int              errors;

    function new();
      q_start = 0;
      q_end   = 5898240;
      dur     = 200;
      mode    = MODE_QUINTIC;
      ticks   = 0;
      done    = 0;
      wr_cnt  = 0;
      rd_cnt  = 0;
      errors  = 0;
    endfunction

    function int unsigned pending();
      return wr_cnt - rd_cnt;
    endfunction

    function void set_reg(reg_idx_t idx, logic [ANGLE_W-1:0] v);
      case (idx)
        REG_START: q_start = longint'($signed(v));
        REG_END:   q_end   = longint'($signed(v));
        REG_DUR:   dur     = 64'(v[15:0]);
        REG_MODE:  mode    = v[0];
        default: ;
      endcase
    endfunction

    // Q.30 product with round half up
    function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // round to nearest, ties away from zero
    function longint round_div(longint num, longint unsigned den);
      longint unsigned mag, q;
      mag = (num < 0) ? longint'(-num) : num;
      q   = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void note_tick(bit rst_cnt);
      longint unsigned n, k, s, s2, s3, s4, s5, scale;
      longint d, p, p1, p2, a;
      sample_t e;
      n = (dur == 0) ? 1 : dur;
      if (rst_cnt) begin
        ticks = 0;
        done  = 0;
      end
      k = ticks;
      if (done || k >= n) k = n;
      s  = ((k << 30) + n / 2) / n;
      s2 = q30_mul(s, s);
      s3 = q30_mul(s2, s);
      s4 = q30_mul(s3, s);
      s5 = q30_mul(s4, s);
      if (mode == MODE_QUINTIC) begin
        p  = 10 * longint'(s3) - 15 * longint'(s4) + 6 * longint'(s5);
        p1 = 30 * longint'(s2) - 60 * longint'(s3) + 30 * longint'(s4);
        p2 = 60 * longint'(s) - 180 * longint'(s2) + 120 * longint'(s3);
      end else begin
        p  = 3 * longint'(s2) - 2 * longint'(s3);
        p1 = 6 * longint'(s) - 6 * longint'(s2);
        p2 = 6 * (64'sd1 <<< 30) - 12 * longint'(s);
      end
      d     = q_end - q_start;
      scale = 64'd1 << RATE_SHIFT;
      a       = clip(q_start + round_div(d * p, 64'd1 << 30), -(64'sd1 <<< 25),
                     (64'sd1 <<< 25) - 1);
      e.ang   = a[ANGLE_W-1:0];
      a       = clip(round_div(d * p1, n * scale), -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
      e.rate  = a[WIDE_W-1:0];
      a       = clip(round_div(d * p2, n * n * scale), -(64'sd1 <<< 47),
                     (64'sd1 <<< 47) - 1);
      e.accel = a[WIDE_W-1:0];
      e.tick  = k[TICK_BITS-1:0];
      e.last  = (k == n);
      if (e.last) begin
        ticks = k;
        done  = 1;
      end else begin
        ticks = (k + 1) & 64'hFFFF;
      end
      pend[wr_cnt % PEND_DEPTH] = e;
      wr_cnt++;
    endfunction

    function void check_sample(sample_t got);
      sample_t e;
      if (pending() == 0) begin
        $display("%0t: unexpected sample, tick %0d", $time, got.tick);
        errors++;
        return;
      end
      e = pend[rd_cnt % PEND_DEPTH];
      rd_cnt++;
      if (got.tick !== e.tick) begin
        $display("%0t: tick_index exp %0d got %0d", $time, e.tick, got.tick);
        errors++;
      end
      if (got.ang !== e.ang) begin
        $display("%0t: angle exp %0d got %0d", $time, e.ang, got.ang);
        errors++;
      end
      if (got.rate !== e.rate) begin
        $display("%0t: angular_rate exp %0d got %0d", $time, e.rate, got.rate);
        errors++;
      end
      if (got.accel !== e.accel) begin
        $display("%0t: angular_accel exp %0d got %0d", $time, e.accel, got.accel);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last_sample exp %0b got %0b", $time, e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [1:0]                cfg_index = '0;
  logic [ANGLE_W-1:0]        cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      restart = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b1;
  logic [TICK_BITS-1:0]      tick_index;
  logic signed [ANGLE_W-1:0] angle;
  logic signed [WIDE_W-1:0]  angular_rate;
  logic signed [WIDE_W-1:0]  angular_accel;
  logic                      last_sample;

  traj_board board = new();
  int  sent = 0;
  bit  send_quiet = 0;   // no gaps between requests
  bit  recv_quiet = 0;   // receiver never stalls

  polynomial_joint_trajectory dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .tick_index(tick_index), .angle(angle), .angular_rate(angular_rate),
    .angular_accel(angular_accel), .last_sample(last_sample)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop if the block hangs
  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // register write, only called with nothing in flight
  task automatic write_reg(reg_idx_t idx, logic [ANGLE_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    board.set_reg(idx, v);
  endtask

  // drain: all samples back, then a margin for the block to go idle
  task automatic wait_drained();
    while (board.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // one tick request; called at a falling edge, returns at a falling edge
  task automatic send_tick(bit r);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= r;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    board.note_tick(r);
    sent++;
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [ANGLE_W-1:0] rand_angle();
    int v;
    case ($urandom_range(0, 4))
      0: v = ANGLE_LIM;
      1: v = -ANGLE_LIM;
      default: v = int'($urandom_range(0, 2 * ANGLE_LIM)) - ANGLE_LIM;
    endcase
    return v[ANGLE_W-1:0];
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_dur();
    int c;
    c = $urandom_range(0, 19);
    if (c < 13) return ANGLE_W'($urandom_range(1, 30));
    if (c < 17) return ANGLE_W'($urandom_range(31, 400));
    if (c < 18) return ANGLE_W'(0);
    if (c < 19) return ANGLE_W'(65535);
    return ANGLE_W'($urandom_range(1, 65535));
  endfunction

  // receiver: random stall per sample, checks every accepted sample
  initial begin
    int gap;
    sample_t got;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = recv_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (out_valid && !out_stall) break;
      end
      got.tick  = tick_index;
      got.ang   = angle;
      got.rate  = angular_rate;
      got.accel = angular_accel;
      got.last  = last_sample;
      board.check_sample(got);
      @(negedge clk);
    end
  end

  initial begin
    int n_items;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: default registers, restart at the start and mid-move
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    end_burst();
    // hold off the sender until the pipe is empty
    wait_drained();

    // single-tick move: k = 0 first, then the last sample k = N, which repeats
    write_reg(REG_DUR, ANGLE_W'(1));
    write_reg(REG_MODE, ANGLE_W'(MODE_CUBIC));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    end_burst();
    wait_drained();

    // zero duration acts as one tick; full-scale swing downward
    write_reg(REG_DUR, ANGLE_W'(0));
    write_reg(REG_START, ANGLE_W'(ANGLE_LIM));
    write_reg(REG_END, ANGLE_W'(-ANGLE_LIM));
    send_tick(1'b1);
    send_tick(1'b0);
    end_burst();
    wait_drained();

    // full-scale upward swing, short quintic move; no restart, so every request repeats the end sample
    write_reg(REG_START, ANGLE_W'(-ANGLE_LIM));
    write_reg(REG_END, ANGLE_W'(ANGLE_LIM));
    write_reg(REG_DUR, ANGLE_W'(3));
    write_reg(REG_MODE, ANGLE_W'(MODE_QUINTIC));
    send_quiet = 1;
    recv_quiet = 1;
    repeat (6) send_tick(1'b0);
    end_burst();
    wait_drained();

    // longest move; then shorten it so the counter sits past the end
    write_reg(REG_DUR, ANGLE_W'(65535));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    end_burst();
    wait_drained();
    write_reg(REG_DUR, ANGLE_W'(2));
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    end_burst();
    wait_drained();

    // Random phases: mostly clean moves with random registers
    while (sent < TARGET_ITEMS - 60) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) write_reg(REG_START, rand_angle());
      if ($urandom_range(0, 1)) write_reg(REG_END, rand_angle());
      if ($urandom_range(0, 3) != 0) write_reg(REG_DUR, rand_dur());
      if ($urandom_range(0, 1)) write_reg(REG_MODE, ANGLE_W'($urandom_range(0, 1)));
      n_items = $urandom_range(20, 100);
      repeat (n_items) send_tick($urandom_range(0, 15) == 0);
      end_burst();
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
